### rtl/interval_list_overlap_length_macros.svh
// assertion macros for the interval list overlap length block
// expects clk and arst_n in the scope where a macro is used
`ifndef INTERVAL_LIST_OVERLAP_LENGTH_MACROS_SVH
`define INTERVAL_LIST_OVERLAP_LENGTH_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ILOL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define ILOL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ilol_pkg.sv
// shared types and constants for the interval list overlap length block
// no dependencies
package ilol_pkg;

	// configuration port
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_COUNT_W = 11;
	localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL_COUNT = 3'd0;
	localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 11'd1;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// list selector carried in tuser
	localparam logic CMD_LIST_A = 1'b0;
	localparam logic CMD_LIST_B = 1'b1;

	// what the back end does with one queued word
	typedef struct packed {
		logic store;
		logic to_b;
		logic merge;
	} ilol_op_ctrl_t;

	// back end status seen by the top level
	typedef struct packed {
		logic busy;
		logic result_wait;
	} ilol_back_stat_t;

endpackage

### rtl/interval_list_overlap_length.sv
// Interval list overlap length. Words on the input stream load half-open intervals
// [begin, finish) into list A (tuser 0) or list B (tuser 1), one word per cycle while the
// queue has room; each list holds interval_count entries. When the word that completes
// both lists is taken, the block walks both lists with two pointers and returns one output
// word with the summed overlap, saturating at the largest coordinate; a word sent to a full
// list is dropped. Each pointer step of the merge puts out the addresses, then takes the
// registered read data from each list ram, for at most 2*count-1 steps; the queue hand-off,
// the last accumulate and the result load follow. The four-word queue lets the input run up
// to four words ahead while a merge runs; a finished result waits in the output register,
// and the next merge holds its result, and takes no further words, until it is taken.
// depends on ilol_pkg, ilol_front, ilol_back, ilol_ram and the assertion macro header
`include "interval_list_overlap_length_macros.svh"

module interval_list_overlap_length
	import ilol_pkg::*;
#(
	parameter int MAX_INTERVALS = 1024,
	parameter int COORD_BITS    = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,  // span_begin, span_finish
	input  logic                                 s_tuser,  // command
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((COORD_BITS+7)/8)*8-1:0]      m_tdata,  // overlap_total
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [CFG_ADDR_W-1:0]                paddr,
	input  logic [CFG_DATA_W-1:0]                pwdata,
	output logic [CFG_DATA_W-1:0]                prdata,
	output logic                                 pready
);

	localparam int AW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW  = $clog2(MAX_INTERVALS + 1);
	localparam int ODW = ((COORD_BITS + 7) / 8) * 8;

	logic [CFG_COUNT_W-1:0] count_q;
	logic                   reg_hit;
	logic                   op_valid, op_ready;
	ilol_op_ctrl_t          op_ctrl;
	logic [AW-1:0]          op_addr;
	logic [CW-1:0]          op_count;
	logic [COORD_BITS-1:0]  op_begin, op_finish, out_total;
	ilol_back_stat_t        back_stat;

	// configuration register, word addressed
	assign pready  = 1'b1;
	assign reg_hit = paddr[CFG_ADDR_W-1:2] == REG_INTERVAL_COUNT[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			count_q <= pwdata[CFG_COUNT_W-1:0];
		end
	end

	assign prdata = reg_hit ? CFG_DATA_W'(count_q) : '0;

	// word intake and fill tracking
	ilol_front #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_begin  (s_tdata[COORD_BITS-1:0]),
		.in_finish (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.cfg_count (count_q),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op_ctrl   (op_ctrl),
		.op_addr   (op_addr),
		.op_count  (op_count),
		.op_begin  (op_begin),
		.op_finish (op_finish)
	);

	// list storage and merge
	ilol_back #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op_ctrl   (op_ctrl),
		.op_addr   (op_addr),
		.op_count  (op_count),
		.op_begin  (op_begin),
		.op_finish (op_finish),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_total (out_total),
		.stat      (back_stat)
	);

	assign m_tdata = ODW'(out_total);

	// checks
	`ILOL_ASSERT_NOW(a_store_in_range, op_valid && op_ready && op_ctrl.store, CW'(op_addr) < op_count, "list write beyond the active count")
	`ILOL_ASSERT_NEXT(a_merge_starts, op_valid && op_ready && op_ctrl.merge, back_stat.busy, "merge word taken but back end did not start")
	`ILOL_ASSERT_NOW(a_result_from_merge, $rose(m_tvalid), $past(back_stat.result_wait), "result shown without a finished merge")

endmodule

### rtl/ilol_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ilol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/ilol_front.sv
// front end: accepts interval words, tracks list fill counts, queues work for the back end
// depends on ilol_pkg
module ilol_front
	import ilol_pkg::*;
#(
	parameter int MAX_INTERVALS = 1024,
	parameter int COORD_BITS    = 24,
	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
	localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_cmd,
	input  logic [COORD_BITS-1:0]  in_begin,
	input  logic [COORD_BITS-1:0]  in_finish,
	input  logic [CFG_COUNT_W-1:0] cfg_count,
	output logic                   op_valid,
	input  logic                   op_ready,
	output ilol_op_ctrl_t          op_ctrl,
	output logic [AW-1:0]          op_addr,
	output logic [CW-1:0]          op_count,
	output logic [COORD_BITS-1:0]  op_begin,
	output logic [COORD_BITS-1:0]  op_finish
);

	logic [CW-1:0] eff_count;
	logic [CW-1:0] loaded_a_q, loaded_b_q;
	logic [CW-1:0] cur_loaded, next_a, next_b;
	logic          accept, store, merge;

	ilol_op_ctrl_t         q_ctrl_q   [QUEUE_DEPTH];
	logic [AW-1:0]         q_addr_q   [QUEUE_DEPTH];
	logic [CW-1:0]         q_count_q  [QUEUE_DEPTH];
	logic [COORD_BITS-1:0] q_begin_q  [QUEUE_DEPTH];
	logic [COORD_BITS-1:0] q_finish_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     fill_q;
	logic                  pop;

	// clamp the configured count into 1..MAX_INTERVALS
	always_comb begin
		if (cfg_count == '0) begin
			eff_count = CW'(1);
		end else if (32'(cfg_count) > MAX_INTERVALS) begin
			eff_count = CW'(MAX_INTERVALS);
		end else begin
			eff_count = CW'(cfg_count);
		end
	end

	// classify the incoming word
	assign accept     = in_valid && in_ready;
	assign cur_loaded = (in_cmd == CMD_LIST_B) ? loaded_b_q : loaded_a_q;
	assign store      = cur_loaded < eff_count;
	assign next_a     = loaded_a_q + CW'(store && (in_cmd == CMD_LIST_A));
	assign next_b     = loaded_b_q + CW'(store && (in_cmd == CMD_LIST_B));
	assign merge      = (next_a >= eff_count) && (next_b >= eff_count);

	// fill counts, cleared when a merge is queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_a_q <= '0;
			loaded_b_q <= '0;
		end else if (accept) begin
			if (merge) begin
				loaded_a_q <= '0;
				loaded_b_q <= '0;
			end else begin
				loaded_a_q <= next_a;
				loaded_b_q <= next_b;
			end
		end
	end

	// queue pointers
	assign in_ready = fill_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign op_valid = fill_q != '0;
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			fill_q <= fill_q + (QUEUE_AW+1)'(accept) - (QUEUE_AW+1)'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_ctrl_q[wr_ptr_q]   <= '{store: store, to_b: in_cmd == CMD_LIST_B, merge: merge};
			q_addr_q[wr_ptr_q]   <= cur_loaded[AW-1:0];
			q_count_q[wr_ptr_q]  <= eff_count;
			q_begin_q[wr_ptr_q]  <= in_begin;
			q_finish_q[wr_ptr_q] <= in_finish;
		end
	end

	assign op_ctrl   = q_ctrl_q[rd_ptr_q];
	assign op_addr   = q_addr_q[rd_ptr_q];
	assign op_count  = q_count_q[rd_ptr_q];
	assign op_begin  = q_begin_q[rd_ptr_q];
	assign op_finish = q_finish_q[rd_ptr_q];

endmodule

### rtl/ilol_back.sv
// back end: writes list entries and runs the two-pointer merge over both list rams
// depends on ilol_pkg and ilol_ram
module ilol_back
	import ilol_pkg::*;
#(
	parameter int MAX_INTERVALS = 1024,
	parameter int COORD_BITS    = 24,
	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
	localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_ready,
	input  ilol_op_ctrl_t         op_ctrl,
	input  logic [AW-1:0]         op_addr,
	input  logic [CW-1:0]         op_count,
	input  logic [COORD_BITS-1:0] op_begin,
	input  logic [COORD_BITS-1:0] op_finish,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] out_total,
	output ilol_back_stat_t       stat
);

	localparam int EW = 2 * COORD_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         i_q, j_q, cnt_q, i_nx, j_nx;
	logic [COORD_BITS-1:0] total_q, ovl_q, out_total_q;
	logic                  pend_q, out_valid_q;
	logic                  we_a, we_b, a_first, done;
	logic [EW-1:0]         wdata, a_rd, b_rd;
	logic [COORD_BITS-1:0] a_beg, a_fin, b_beg, b_fin, lo, hi, ovl;
	logic [COORD_BITS:0]   sum;

	// list stores
	assign op_ready = state_q == ST_IDLE;
	assign wdata    = {op_finish, op_begin};
	assign we_a     = op_ready && op_valid && op_ctrl.store && !op_ctrl.to_b;
	assign we_b     = op_ready && op_valid && op_ctrl.store && op_ctrl.to_b;

	ilol_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (op_addr),
		.wdata (wdata),
		.raddr (i_q[AW-1:0]),
		.rdata (a_rd)
	);

	ilol_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (op_addr),
		.wdata (wdata),
		.raddr (j_q[AW-1:0]),
		.rdata (b_rd)
	);

	// one merge step on the pair just read
	assign a_beg   = a_rd[COORD_BITS-1:0];
	assign a_fin   = a_rd[EW-1:COORD_BITS];
	assign b_beg   = b_rd[COORD_BITS-1:0];
	assign b_fin   = b_rd[EW-1:COORD_BITS];
	assign lo      = (a_beg > b_beg) ? a_beg : b_beg;
	assign hi      = (a_fin < b_fin) ? a_fin : b_fin;
	assign ovl     = (hi > lo) ? (hi - lo) : '0;
	assign a_first = a_fin < b_fin;
	assign i_nx    = i_q + CW'(a_first);
	assign j_nx    = j_q + CW'(!a_first);
	assign done    = (i_nx >= cnt_q) || (j_nx >= cnt_q);

	// saturating accumulate of the previous step
	assign sum = {1'b0, total_q} + {1'b0, ovl_q};

	// merge sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			ovl_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_total_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_q) begin
				total_q <= sum[COORD_BITS] ? '1 : sum[COORD_BITS-1:0];
				pend_q  <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid && op_ctrl.merge) begin
						i_q     <= '0;
						j_q     <= '0;
						cnt_q   <= op_count;
						total_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					ovl_q   <= ovl;
					pend_q  <= 1'b1;
					i_q     <= i_nx;
					j_q     <= j_nx;
					state_q <= done ? ST_FIN : ST_READ;
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_total_q <= total_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign out_total        = out_total_q;
	assign stat.busy        = state_q != ST_IDLE;
	assign stat.result_wait = state_q == ST_OUT;

endmodule

### tb/sv/interval_list_overlap_length_tb.sv
// self-checking testbench for interval_list_overlap_length: loads list pairs over the input
// stream, predicts each overlap total and checks every output word against that prediction
// depends on ilol_pkg and the interval_list_overlap_length rtl
module interval_list_overlap_length_tb;
	import ilol_pkg::*;

	localparam int MAX_ENTRIES = 1024;
	localparam int COORD_W     = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_ITEMS_PER_PHASE = 100;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {SHAPE_SORTED, SHAPE_NOISE, SHAPE_OVERFILL} set_shape_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;  // span_begin, span_finish
	logic                  s_tuser = 1'b0;  // command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;  // overlap_total
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// predictor state
	logic [COORD_W-1:0]     a_begin [MAX_ENTRIES];
	logic [COORD_W-1:0]     a_finish [MAX_ENTRIES];
	logic [COORD_W-1:0]     b_begin [MAX_ENTRIES];
	logic [COORD_W-1:0]     b_finish [MAX_ENTRIES];
	int                     loaded_a = 0;
	int                     loaded_b = 0;
	logic [CFG_COUNT_W-1:0] cfg_count = COUNT_RESET;
	logic [COORD_W-1:0]     pending_totals [$];
	logic [COORD_W-1:0]     front_total;

	// stimulus state
	logic [COORD_W-1:0] gen_begin [2][MAX_ENTRIES];
	logic [COORD_W-1:0] gen_finish [2][MAX_ENTRIES];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 holds_asked = 0;
	int                 holds_started = 0;
	int                 hold_left = 0;
	int                 random_items = 0;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;

	interval_list_overlap_length DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// count of zero acts as one, counts above the list depth are clipped
	function automatic int effective_count();
		int c;
		c = int'(cfg_count);
		if (c == 0) c = 1;
		if (c > MAX_ENTRIES) c = MAX_ENTRIES;
		return c;
	endfunction

	function automatic int drain_cycles();
		return 4 * effective_count() + 16;
	endfunction

	// two-pointer walk: the list whose interval ends first steps, b steps on a tie
	function automatic logic [COORD_W-1:0] overlap_of_lists(int n);
		int i = 0;
		int j = 0;
		logic [COORD_W:0] sum = '0;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		while (i < n && j < n) begin
			lo = (a_begin[i] > b_begin[j]) ? a_begin[i] : b_begin[j];
			hi = (a_finish[i] < b_finish[j]) ? a_finish[i] : b_finish[j];
			if (hi > lo) begin
				sum = sum + (hi - lo);
				if (sum > {1'b0, {COORD_W{1'b1}}}) sum = {1'b0, {COORD_W{1'b1}}};
			end
			if (a_finish[i] < b_finish[j]) i++;
			else j++;
		end
		return sum[COORD_W-1:0];
	endfunction

	// one accepted word: store it unless its list is full, merge when both lists are full
	function automatic void apply_word(logic cmd, logic [COORD_W-1:0] b, logic [COORD_W-1:0] f);
		int n;
		n = effective_count();
		if (cmd == CMD_LIST_A) begin
			if (loaded_a < n) begin
				a_begin[loaded_a] = b;
				a_finish[loaded_a] = f;
				loaded_a++;
			end
		end else begin
			if (loaded_b < n) begin
				b_begin[loaded_b] = b;
				b_finish[loaded_b] = f;
				loaded_b++;
			end
		end
		if (loaded_a >= n && loaded_b >= n) begin
			pending_totals = {pending_totals, overlap_of_lists(n)};
			loaded_a = 0;
			loaded_b = 0;
		end
	endfunction

	// input and output monitor, prediction before the check
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				apply_word(s_tuser, s_tdata[23:0], s_tdata[47:24]);
			if (m_tvalid && m_tready) begin
				if (pending_totals.size() == 0) begin
					mismatch_count++;
					$display("%0t: overlap_total expected none, actual %h", $time, m_tdata);
				end else begin
					front_total = pending_totals.pop_front();
					if (m_tdata !== front_total) begin
						mismatch_count++;
						$display("%0t: overlap_total expected %h, actual %h",
							$time, front_total, m_tdata);
					end
				end
			end
		end
	end

	// output side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_started != holds_asked) begin
			m_tready <= 1'b0;
			hold_left <= LONG_HOLD;
			holds_started <= holds_started + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		unique case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 58;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 58;
			end
			default: begin
				send_idle_pct = 15;
				recv_stall_pct = 15;
			end
		endcase
	endtask

	// offer one word, with random gaps ahead of it, and wait until it is taken
	task automatic send_interval(input logic cmd, input logic [COORD_W-1:0] b,
		input logic [COORD_W-1:0] f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {f, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering, let every expected total come back, then let the block settle
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (drain_cycles()) @(posedge clk);
	endtask

	// register write then readback, only with the block idle
	task automatic write_count(input logic [CFG_COUNT_W-1:0] value);
		wait_until_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_INTERVAL_COUNT;
		pwdata <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_count = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[CFG_COUNT_W-1:0] !== value) begin
			mismatch_count++;
			$display("%0t: interval_count readback expected %h, actual %h",
				$time, value, prdata[CFG_COUNT_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// sorted, disjoint list: one slot per interval, each interval inside its slot
	function automatic void build_sorted(input logic list, input int n, input int unsigned top);
		int unsigned slot;
		int unsigned b;
		slot = top / n;
		for (int i = 0; i < n; i++) begin
			b = i * slot + $urandom_range(0, slot / 2);
			gen_begin[list][i] = b[COORD_W-1:0];
			gen_finish[list][i] = COORD_W'(b + $urandom_range(0, slot / 2));
		end
	endfunction

	// one data set of n intervals per list
	task automatic send_data_set(input int n, input set_shape_t shape);
		int ia = 0;
		int ib = 0;
		int unsigned top;
		logic first;
		top = ($urandom_range(3) == 0) ? 32'hFFFFFF : ((32'd1 << $urandom_range(12, 23)) - 1);
		build_sorted(CMD_LIST_A, n, top);
		build_sorted(CMD_LIST_B, n, top);
		// random content: unsorted, overlapping and reversed intervals
		if (shape == SHAPE_NOISE) begin
			for (int i = 0; i < 2 * n; i++) begin
				gen_begin[i % 2][i / 2] = COORD_W'($urandom);
				gen_finish[i % 2][i / 2] = $urandom_range(1) ? COORD_W'($urandom)
					: gen_begin[i % 2][i / 2] + COORD_W'($urandom_range(0, 255));
			end
		end
		if (shape == SHAPE_OVERFILL) begin
			// fill one list, push a few words into it while full, then fill the other
			first = 1'($urandom_range(1));
			for (int i = 0; i < n; i++)
				send_interval(first, gen_begin[first][i], gen_finish[first][i]);
			repeat ($urandom_range(1, 3))
				send_interval(first, COORD_W'($urandom), COORD_W'($urandom));
			for (int i = 0; i < n; i++)
				send_interval(!first, gen_begin[!first][i], gen_finish[!first][i]);
		end else begin
			// random interleave of the two lists
			while (ia < n || ib < n) begin
				if (ib >= n || (ia < n && $urandom_range(1) == 0)) begin
					send_interval(CMD_LIST_A, gen_begin[CMD_LIST_A][ia], gen_finish[CMD_LIST_A][ia]);
					ia++;
				end else begin
					send_interval(CMD_LIST_B, gen_begin[CMD_LIST_B][ib], gen_finish[CMD_LIST_B][ib]);
					ib++;
				end
			end
		end
	endtask

	// single intervals: coordinate extremes, empty and reversed spans, full list, count of zero
	task automatic test_single_intervals();
		write_count(11'd1);
		send_interval(CMD_LIST_A, 24'h000000, 24'hFFFFFF);
		send_interval(CMD_LIST_B, 24'h000000, 24'hFFFFFF);
		send_interval(CMD_LIST_B, 24'hFFFFFF, 24'hFFFFFF);
		send_interval(CMD_LIST_A, 24'hFFFFFF, 24'hFFFFFF);
		send_interval(CMD_LIST_B, 24'h555555, 24'hF0F0F0);
		send_interval(CMD_LIST_A, 24'hAAAAAA, 24'hFFFFFF);
		send_interval(CMD_LIST_A, 24'h000100, 24'h000050);
		send_interval(CMD_LIST_B, 24'h000000, 24'h000200);
		// second word to list a is dropped
		send_interval(CMD_LIST_A, 24'h000010, 24'h000020);
		send_interval(CMD_LIST_A, 24'h000000, 24'h001000);
		send_interval(CMD_LIST_B, 24'h000000, 24'h001000);
		write_count(11'd0);
		send_interval(CMD_LIST_A, 24'h000005, 24'h000009);
		send_interval(CMD_LIST_B, 24'h000007, 24'h000100);
	endtask

	// two entries per list: saturating sum and the tie on equal ends
	task automatic test_merge_rules();
		write_count(11'd2);
		send_interval(CMD_LIST_A, 24'h000000, 24'hFFFFFF);
		send_interval(CMD_LIST_A, 24'h000000, 24'hFFFFFF);
		send_interval(CMD_LIST_B, 24'h000000, 24'hFFFFFF);
		send_interval(CMD_LIST_B, 24'h000001, 24'hFFFFFF);
		send_interval(CMD_LIST_A, 24'h000000, 24'h000010);
		send_interval(CMD_LIST_B, 24'h000005, 24'h000010);
		send_interval(CMD_LIST_A, 24'h000010, 24'h000020);
		send_interval(CMD_LIST_B, 24'h000012, 24'h000030);
	endtask

	// count lowered while both lists are partly loaded
	task automatic test_count_lowered();
		write_count(11'd1024);
		build_sorted(CMD_LIST_A, 40, 32'hFFFFFF);
		build_sorted(CMD_LIST_B, 40, 32'hFFFFFF);
		for (int i = 0; i < 40; i++)
			send_interval(CMD_LIST_A, gen_begin[CMD_LIST_A][i], gen_finish[CMD_LIST_A][i]);
		for (int i = 0; i < 30; i++)
			send_interval(CMD_LIST_B, gen_begin[CMD_LIST_B][i], gen_finish[CMD_LIST_B][i]);
		write_count(11'd20);
		send_interval(CMD_LIST_B, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// largest register value clips to the list depth: list a fills, extra words are dropped,
	// then a lowered count merges on the first entries
	task automatic test_largest_count();
		write_count(11'd2047);
		build_sorted(CMD_LIST_A, MAX_ENTRIES, 32'hFFFFFF);
		for (int i = 0; i < MAX_ENTRIES; i++)
			send_interval(CMD_LIST_A, gen_begin[CMD_LIST_A][i], gen_finish[CMD_LIST_A][i]);
		repeat (2) send_interval(CMD_LIST_A, COORD_W'($urandom), COORD_W'($urandom));
		write_count(11'd1);
		send_interval(CMD_LIST_B, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// long output hold-off so the block fills and stalls its input
	task automatic test_backpressure();
		write_count(11'd1);
		set_idling(IDLE_NONE);
		holds_asked = holds_asked + 1;
		repeat (30) send_data_set(1, SHAPE_SORTED);
		wait_until_drained();
	endtask

	// random data sets under one idling mode
	task automatic run_random_phase(input idle_mode_t mode);
		int phase_end;
		int pick;
		logic [CFG_COUNT_W-1:0] value;
		set_idling(mode);
		phase_end = random_items + RANDOM_ITEMS_PER_PHASE;
		while (random_items < phase_end) begin
			value = ($urandom_range(9) == 0) ? CFG_COUNT_W'($urandom_range(9, 40))
				: CFG_COUNT_W'($urandom_range(1, 8));
			if ($urandom_range(19) == 0) value = '0;
			write_count(value);
			repeat (3) begin
				pick = $urandom_range(99);
				if (pick < 70) send_data_set(effective_count(), SHAPE_SORTED);
				else if (pick < 85) send_data_set(effective_count(), SHAPE_NOISE);
				else send_data_set(effective_count(), SHAPE_OVERFILL);
				random_items = random_items + 2 * effective_count();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(IDLE_NONE);
		test_single_intervals();
		test_merge_rules();
		test_count_lowered();
		test_largest_count();
		test_backpressure();
		run_random_phase(IDLE_NONE);
		run_random_phase(IDLE_SENDER);
		run_random_phase(IDLE_RECEIVER);
		run_random_phase(IDLE_BOTH);
		wait_until_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
